// File: sv/ann_pkg.sv
package ann_pkg;

  typedef struct packed {
    logic signed [47:0] current_score;
    logic signed [47:0] candidate_score;
    logic [23:0]        iteration_number;
    logic [31:0]        candidate_number;
  } ann_in_t;

  typedef struct packed {
    logic        accepted;
    logic        accepted_worse;
    logic [32:0] probability;
    logic [47:0] temperature_value;
  } ann_out_t;

  typedef enum logic [1:0] {
    CFG_PROFILE   = 2'd0,
    CFG_MAX_ITER  = 2'd1,
    CFG_HASH_SEED = 2'd2
  } ann_cfg_e;

  typedef enum logic [1:0] {
    PROF_FAST     = 2'd0,
    PROF_BALANCED = 2'd1,
    PROF_MAXIMUM  = 2'd2
  } ann_prof_e;

  localparam logic [32:0] ONE_Q32   = 33'h1_0000_0000;
  localparam logic [31:0] LN2_Q32   = 32'd2977044472;
  localparam logic [24:0] LOG2E_Q24 = 25'd24204406;
  localparam logic [47:0] T_MIN     = 48'd65536;

  // schedule factors per profile: init in Q0.32, log2(init/final) in Q3.28
  localparam logic [27:0] INIT_FAST     = 28'd6442451;
  localparam logic [27:0] INIT_BALANCED = 28'd42949673;
  localparam logic [27:0] INIT_MAXIMUM  = 28'd150323855;
  localparam logic [30:0] RLOG_FAST     = 31'd1317183415;
  localparam logic [30:0] RLOG_BALANCED = 31'd1160158739;
  localparam logic [30:0] RLOG_MAXIMUM  = 31'd1219856751;

  localparam logic [63:0] HASH_C1 = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] HASH_C2 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] HASH_C3 = 64'h94d049bb133111eb;

  // floor(x/k) for 32-bit x: (x*M) >> (32+SH), M = ceil(2^(32+SH)/k), SH = ceil(log2 k).
  // Powers of two use the shift alone.
  localparam int unsigned RECIP_SH [17] = '{0, 0, 1, 2, 2, 3, 3, 3, 3,
                                            4, 4, 4, 4, 4, 4, 4, 4};
  localparam logic [32:0] RECIP_M [17] = '{
    33'd0, 33'd0, 33'd0,
    33'((64'd1 << 34) / 64'd3 + 64'd1),
    33'd0,
    33'((64'd1 << 35) / 64'd5 + 64'd1),
    33'((64'd1 << 35) / 64'd6 + 64'd1),
    33'((64'd1 << 35) / 64'd7 + 64'd1),
    33'd0,
    33'((64'd1 << 36) / 64'd9 + 64'd1),
    33'((64'd1 << 36) / 64'd10 + 64'd1),
    33'((64'd1 << 36) / 64'd11 + 64'd1),
    33'((64'd1 << 36) / 64'd12 + 64'd1),
    33'((64'd1 << 36) / 64'd13 + 64'd1),
    33'((64'd1 << 36) / 64'd14 + 64'd1),
    33'((64'd1 << 36) / 64'd15 + 64'd1),
    33'd0
  };

endpackage

// File: sv/ann_hash.sv
module ann_hash
  import ann_pkg::*;
#(
  parameter int unsigned SideW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [31:0]      seed_i,
  input  logic [31:0]      cand_i,
  input  logic [23:0]      iter_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [31:0]      draw_o,
  output logic [SideW-1:0] side_o
);

  function automatic logic [31:0] mul_lo(logic [31:0] a, logic [31:0] b);
    logic [63:0] p;
    p = 64'(a) * 64'(b);
    return p[31:0];
  endfunction

  logic [6:0]       vld_q;
  logic [SideW-1:0] side_q [7];

  logic [32:0] a_d, a_q;
  logic [24:0] b_d, b_q;
  logic [63:0] v0_d, v0_q, v0b_q;
  logic [63:0] pa0_d, pa0_q, pb0_d, pb0_q;
  logic [31:0] pa1_d, pa1_q, pb1_d, pb1_q;
  logic        a32_q;
  logic [63:0] x3, y3, v3, v3_d, v3_q;
  logic [63:0] m0_d, m0_q, n0_d, n0_q;
  logic [31:0] m1_d, m1_q, m2_d, m2_q, n1_d, n1_q, n2_d, n2_q;
  logic [63:0] w5, w5_d, w5_q, w7, w7_d;
  logic [31:0] draw_q;

  assign a_d  = {1'b0, cand_i} + 33'd1;
  assign b_d  = {1'b0, iter_i} + 25'd17;
  assign v0_d = 64'(seed_i) + HASH_C1;

  assign pa0_d = 64'(a_q[31:0]) * 64'(HASH_C2[31:0]);
  assign pa1_d = mul_lo(a_q[31:0], HASH_C2[63:32]);
  assign pb0_d = 64'(b_q) * 64'(HASH_C3[31:0]);
  assign pb1_d = mul_lo(32'(b_q), HASH_C3[63:32]);

  // 64x64 products mod 2^64 from a low full product and two low cross terms
  assign x3   = pa0_q + {pa1_q + (a32_q ? HASH_C2[31:0] : 32'd0), 32'd0};
  assign y3   = pb0_q + {pb1_q, 32'd0};
  assign v3   = v0b_q ^ x3 ^ y3;
  assign v3_d = v3 ^ (v3 >> 30);

  assign m0_d = 64'(v3_q[31:0]) * 64'(HASH_C2[31:0]);
  assign m1_d = mul_lo(v3_q[31:0], HASH_C2[63:32]);
  assign m2_d = mul_lo(v3_q[63:32], HASH_C2[31:0]);

  assign w5   = m0_q + {m1_q + m2_q, 32'd0};
  assign w5_d = w5 ^ (w5 >> 27);

  assign n0_d = 64'(w5_q[31:0]) * 64'(HASH_C3[31:0]);
  assign n1_d = mul_lo(w5_q[31:0], HASH_C3[63:32]);
  assign n2_d = mul_lo(w5_q[63:32], HASH_C3[31:0]);

  assign w7   = n0_q + {n1_q + n2_q, 32'd0};
  assign w7_d = w7 ^ (w7 >> 31);

  always_ff @(posedge clk_i) begin
    a_q       <= a_d;
    b_q       <= b_d;
    v0_q      <= v0_d;
    pa0_q     <= pa0_d;
    pa1_q     <= pa1_d;
    pb0_q     <= pb0_d;
    pb1_q     <= pb1_d;
    a32_q     <= a_q[32];
    v0b_q     <= v0_q;
    v3_q      <= v3_d;
    m0_q      <= m0_d;
    m1_q      <= m1_d;
    m2_q      <= m2_d;
    w5_q      <= w5_d;
    n0_q      <= n0_d;
    n1_q      <= n1_d;
    n2_q      <= n2_d;
    draw_q    <= w7_d[63:32];
    side_q[0] <= side_i;
    for (int i = 1; i < 7; i++) begin
      side_q[i] <= side_q[i-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[5:0], valid_i};
    end
  end

  assign valid_o = vld_q[6];
  assign draw_o  = draw_q;
  assign side_o  = side_q[6];

endmodule

// File: sv/ann_div.sv
module ann_div #(
  parameter int unsigned DenW  = 24,
  parameter int unsigned QuoW  = 32,
  parameter int unsigned Steps = 4,
  parameter int unsigned SideW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [DenW-1:0]  rem_i,
  input  logic [DenW-1:0]  den_i,
  input  logic [QuoW-1:0]  feed_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [QuoW-1:0]  quo_o,
  output logic [SideW-1:0] side_o
);

  localparam int unsigned NStg = QuoW / Steps;

  typedef struct packed {
    logic [DenW-1:0]  rem;
    logic [DenW-1:0]  den;
    logic [QuoW-1:0]  feed;
    logic [QuoW-1:0]  quo;
    logic [SideW-1:0] side;
  } div_st_t;

  // restoring division, Steps quotient bits per stage; feed holds the
  // numerator bits still to be shifted in, MSB first
  function automatic div_st_t div_steps(div_st_t a);
    div_st_t      r;
    logic [DenW:0] t;
    r = a;
    for (int i = 0; i < Steps; i++) begin
      t      = {r.rem, r.feed[QuoW-1]};
      r.feed = r.feed << 1;
      if (t >= {1'b0, r.den}) begin
        t     = t - {1'b0, r.den};
        r.quo = {r.quo[QuoW-2:0], 1'b1};
      end else begin
        r.quo = {r.quo[QuoW-2:0], 1'b0};
      end
      r.rem = t[DenW-1:0];
    end
    return r;
  endfunction

  div_st_t        st_d [NStg+1];
  div_st_t        st_q [NStg+1];
  logic [NStg:0]  vld_q;

  assign st_d[0] = '{rem: rem_i, den: den_i, feed: feed_i, quo: '0, side: side_i};

  for (genvar g = 1; g <= NStg; g++) begin : g_stg
    assign st_d[g] = div_steps(st_q[g-1]);
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i <= NStg; i++) begin
      st_q[i] <= st_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NStg-1:0], valid_i};
    end
  end

  assign valid_o = vld_q[NStg];
  assign quo_o   = st_q[NStg].quo;
  assign side_o  = st_q[NStg].side;

endmodule

// File: sv/ann_exp2.sv
module ann_exp2
  import ann_pkg::*;
#(
  parameter int unsigned UW    = 35,
  parameter int unsigned SideW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [UW-1:0]    u_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [32:0]      e_o,
  output logic [SideW-1:0] side_o
);

  // 2^-u for u in Q.32: Taylor series of exp(-f*ln2), sixteen terms; terms 2 to 16
  // take two stages each (term*y, then the divide by k), then the integer shift.

  typedef struct packed {
    logic             big;
    logic [5:0]       n;
    logic [31:0]      y;
    logic [31:0]      term;
    logic [32:0]      s;
    logic [SideW-1:0] side;
  } lane_t;

  typedef struct packed {
    logic             big;
    logic [5:0]       n;
    logic [31:0]      y;
    logic [31:0]      prod;
    logic [32:0]      s;
    logic [SideW-1:0] side;
  } mid_t;

  lane_t lane_d [17];
  lane_t lane_q [17];
  mid_t  mid_d  [2:16];
  mid_t  mid_q  [2:16];

  logic [16:0]      vl_q;
  logic [16:2]      vm_q;
  logic             vo_q;
  logic [32:0]      e_d, e_q;
  logic [SideW-1:0] side_q;
  logic [UW-1:0]    n_wide;
  logic [63:0]      y_prod;

  assign n_wide = u_i >> 32;
  assign y_prod = 64'(u_i[31:0]) * 64'(LN2_Q32);

  assign lane_d[0] = '{big: (n_wide >= UW'(33)), n: n_wide[5:0], y: y_prod[63:32],
                       term: '0, s: ONE_Q32, side: side_i};

  assign lane_d[1] = '{big: lane_q[0].big, n: lane_q[0].n, y: lane_q[0].y,
                       term: lane_q[0].y, s: ONE_Q32 - 33'(lane_q[0].y),
                       side: lane_q[0].side};

  for (genvar K = 2; K <= 16; K++) begin : g_term
    localparam bit Pow2 = ((K & (K - 1)) == 0);
    logic [63:0] tp;
    logic [31:0] tq;

    assign tp       = 64'(lane_q[K-1].term) * 64'(lane_q[K-1].y);
    assign mid_d[K] = '{big: lane_q[K-1].big, n: lane_q[K-1].n, y: lane_q[K-1].y,
                        prod: tp[63:32], s: lane_q[K-1].s, side: lane_q[K-1].side};

    if (Pow2) begin : g_shift
      assign tq = mid_q[K].prod >> RECIP_SH[K];
    end else begin : g_recip
      logic [64:0] mp;
      assign mp = 65'(mid_q[K].prod) * 65'(RECIP_M[K]);
      assign tq = 32'(mp >> (32 + RECIP_SH[K]));
    end

    assign lane_d[K] = '{big: mid_q[K].big, n: mid_q[K].n, y: mid_q[K].y, term: tq,
                         s: ((K % 2) == 1) ? mid_q[K].s - 33'(tq) : mid_q[K].s + 33'(tq),
                         side: mid_q[K].side};
  end

  assign e_d = lane_q[16].big ? '0 : (lane_q[16].s >> lane_q[16].n);

  always_ff @(posedge clk_i) begin
    for (int i = 0; i <= 16; i++) begin
      lane_q[i] <= lane_d[i];
    end
    for (int i = 2; i <= 16; i++) begin
      mid_q[i] <= mid_d[i];
    end
    e_q    <= e_d;
    side_q <= lane_q[16].side;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vl_q <= '0;
      vm_q <= '0;
      vo_q <= 1'b0;
    end else begin
      vl_q[0] <= valid_i;
      vl_q[1] <= vl_q[0];
      for (int i = 2; i <= 16; i++) begin
        vm_q[i] <= vl_q[i-1];
        vl_q[i] <= vm_q[i];
      end
      vo_q <= vl_q[16];
    end
  end

  assign valid_o = vo_q;
  assign e_o     = e_q;
  assign side_o  = side_q;

endmodule

// File: sv/annealing_acceptance_test.sv
// Metropolis acceptance test for simulated annealing, fully pipelined.
//
// Input: an item is taken at a rising edge with start_i high and busy_o low.
// busy_o stays low, so one item may be issued every clock.
// Output: done_o is high for one cycle with the result beat on result_o;
// results leave in issue order.
// The receiver has no way to hold results off, and the pipeline never stalls.
// Pipeline order: hash, progress divider, schedule exponent, schedule exp,
// temperature, probability divider, log scale, probability exp, final.
// The 38-bit quotient divider (one quotient bit per stage) and the two
// 33-stage exponential pipelines set the depth.
// Config: cfg_we_i writes cfg_data_i into the register picked by cfg_idx_i
// (profile, max iterations, hash seed); write only while the pipe is empty.
// Reset clears the pipeline valid bits and loads profile balanced, 1000
// iterations and seed 0. No clearing pass is needed after reset.
module annealing_acceptance_test
  import ann_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  ann_in_t     item_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  output logic        done_o,
  output ann_out_t    result_o
);

  typedef struct packed {
    logic signed [47:0] cur;
    logic signed [47:0] cand;
    logic [23:0]        iter;
  } hsh_side_t;

  typedef struct packed {
    logic               full;
    logic [31:0]        draw;
    logic [47:0]        scale;
    logic signed [48:0] delta;
  } prg_side_t;

  typedef struct packed {
    logic [31:0]        draw;
    logic [47:0]        scale;
    logic signed [48:0] delta;
  } tmp_side_t;

  typedef struct packed {
    logic        pos;
    logic        big;
    logic [47:0] temp;
    logic [31:0] draw;
  } prb_side_t;

  // configuration
  logic [1:0]  profile_q;
  logic [23:0] max_iter_q;
  logic [31:0] seed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      profile_q  <= PROF_BALANCED;
      max_iter_q <= 24'd1000;
      seed_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PROFILE:   profile_q  <= cfg_data_i[1:0];
        CFG_MAX_ITER:  max_iter_q <= cfg_data_i[23:0];
        CFG_HASH_SEED: seed_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [27:0] init_sel;
  logic [30:0] rlog_sel;

  always_comb begin
    case (profile_q)
      PROF_FAST: begin
        init_sel = INIT_FAST;
        rlog_sel = RLOG_FAST;
      end
      PROF_MAXIMUM: begin
        init_sel = INIT_MAXIMUM;
        rlog_sel = RLOG_MAXIMUM;
      end
      default: begin
        init_sel = INIT_BALANCED;
        rlog_sel = RLOG_BALANCED;
      end
    endcase
  end

  assign busy_o = 1'b0;

  // hash draw
  hsh_side_t hs_in, hs_out;
  logic      hs_vld;
  logic [31:0] hs_draw;

  assign hs_in = '{cur: item_i.current_score, cand: item_i.candidate_score,
                   iter: item_i.iteration_number};

  ann_hash #(.SideW($bits(hsh_side_t))) u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i),
    .seed_i  (seed_q),
    .cand_i  (item_i.candidate_number),
    .iter_i  (item_i.iteration_number),
    .side_i  (hs_in),
    .valid_o (hs_vld),
    .draw_o  (hs_draw),
    .side_o  (hs_out)
  );

  // progress = iter / (max-1) in Q0.32
  logic        full;
  logic [23:0] den1;
  logic [47:0] acur, acand;
  prg_side_t   p_in, p_out;
  logic        p_vld;
  logic [31:0] prog_quo;

  assign den1  = max_iter_q - 24'd1;
  assign full  = (max_iter_q <= 24'd1) || (hs_out.iter >= den1);
  assign acur  = hs_out.cur[47] ? (~hs_out.cur + 48'd1) : hs_out.cur;
  assign acand = hs_out.cand[47] ? (~hs_out.cand + 48'd1) : hs_out.cand;
  assign p_in  = '{full: full, draw: hs_draw,
                   scale: (acur > acand) ? acur : acand,
                   delta: {hs_out.cand[47], hs_out.cand} - {hs_out.cur[47], hs_out.cur}};

  ann_div #(.DenW(24), .QuoW(32), .Steps(4), .SideW($bits(prg_side_t))) u_div_prog (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (hs_vld),
    .rem_i   (full ? 24'd0 : hs_out.iter),
    .den_i   (den1),
    .feed_i  ('0),
    .side_i  (p_in),
    .valid_o (p_vld),
    .quo_o   (prog_quo),
    .side_o  (p_out)
  );

  // schedule exponent u = progress * log2(init/final)
  logic [34:0] u1_d, u1_q;
  logic [63:0] u1_prod;
  tmp_side_t   u1s_q;
  logic        u1v_q;

  assign u1_prod = 64'(prog_quo) * 64'(rlog_sel);
  assign u1_d    = p_out.full ? {rlog_sel, 4'd0} : u1_prod[62:28];

  logic        e1_vld;
  logic [32:0] g_val;
  tmp_side_t   e1_side;

  ann_exp2 #(.UW(35), .SideW($bits(tmp_side_t))) u_exp_sched (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (u1v_q),
    .u_i     (u1_q),
    .side_i  (u1s_q),
    .valid_o (e1_vld),
    .e_o     (g_val),
    .side_o  (e1_side)
  );

  // factor, then temperature = scale * factor
  logic [63:0] fac_prod;
  logic [27:0] fac_d, fac_q;
  tmp_side_t   fs_q, ms_q, ts_q;
  logic        fv_q, mv_q, tv_q;
  logic [59:0] hi_d, hi_q;
  logic [27:0] lo_d, lo_q;
  logic [43:0] lo_prod;
  logic [60:0] t_sum;
  logic [47:0] temp_d, temp_q;

  assign fac_prod = 64'(g_val[31:0]) * 64'(init_sel);
  assign fac_d    = g_val[32] ? init_sel : fac_prod[59:32];
  assign hi_d     = 60'(fs_q.scale[47:16]) * 60'(fac_q);
  assign lo_prod  = 44'(fs_q.scale[15:0]) * 44'(fac_q);
  assign lo_d     = lo_prod[43:16];
  assign t_sum    = 61'(hi_q) + 61'(lo_q);
  // product tops out near 2^42, so only the lower bound can bind
  assign temp_d   = (48'(t_sum[60:16]) < T_MIN) ? T_MIN : 48'(t_sum[60:16]);

  // probability divider: delta * 2^32 / T
  logic        pos, big;
  logic [47:0] dmag;
  prb_side_t   q_in, q_out;
  logic        q_vld;
  logic [37:0] q_quo;

  assign pos  = !ts_q.delta[48] && (ts_q.delta != '0);
  assign dmag = ts_q.delta[47:0];
  assign big  = {6'd0, dmag} >= {temp_q, 6'd0};
  assign q_in = '{pos: pos, big: big, temp: temp_q, draw: ts_q.draw};

  ann_div #(.DenW(48), .QuoW(38), .Steps(1), .SideW($bits(prb_side_t))) u_div_prob (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (tv_q),
    .rem_i   ((pos && !big) ? {6'd0, dmag[47:6]} : 48'd0),
    .den_i   (temp_q),
    .feed_i  ({dmag[5:0], 32'd0}),
    .side_i  (q_in),
    .valid_o (q_vld),
    .quo_o   (q_quo),
    .side_o  (q_out)
  );

  logic [63:0] u2_prod;
  logic [38:0] u2_q;
  prb_side_t   u2s_q;
  logic        u2v_q;

  assign u2_prod = 64'(q_quo) * 64'(LOG2E_Q24);

  logic        e2_vld;
  logic [32:0] p_val;
  prb_side_t   e2_side;

  ann_exp2 #(.UW(39), .SideW($bits(prb_side_t))) u_exp_prob (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (u2v_q),
    .u_i     (u2_q),
    .side_i  (u2s_q),
    .valid_o (e2_vld),
    .e_o     (p_val),
    .side_o  (e2_side)
  );

  // result
  logic [32:0] prob;
  logic        acc;
  ann_out_t    res_d, res_q;
  logic        done_q;

  always_comb begin
    if (!e2_side.pos) begin
      prob = ONE_Q32;
    end else if (e2_side.big) begin
      prob = '0;
    end else begin
      prob = p_val;
    end
  end

  assign acc   = ({1'b0, e2_side.draw} < prob);
  assign res_d = '{accepted: acc, accepted_worse: acc && e2_side.pos,
                   probability: prob, temperature_value: e2_side.temp};

  always_ff @(posedge clk_i) begin
    u1_q   <= u1_d;
    u1s_q  <= '{draw: p_out.draw, scale: p_out.scale, delta: p_out.delta};
    fac_q  <= fac_d;
    fs_q   <= e1_side;
    hi_q   <= hi_d;
    lo_q   <= lo_d;
    ms_q   <= fs_q;
    temp_q <= temp_d;
    ts_q   <= ms_q;
    u2_q   <= u2_prod[62:24];
    u2s_q  <= q_out;
    res_q  <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u1v_q  <= 1'b0;
      fv_q   <= 1'b0;
      mv_q   <= 1'b0;
      tv_q   <= 1'b0;
      u2v_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      u1v_q  <= p_vld;
      fv_q   <= e1_vld;
      mv_q   <= fv_q;
      tv_q   <= mv_q;
      u2v_q  <= q_vld;
      done_q <= e2_vld;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

// File: dv/annealing_acceptance_test_tb.sv
module annealing_acceptance_test_tb;
  import ann_pkg::*;

  localparam int PIPE_DEPTH = 127;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  ann_in_t     item_i;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;
  logic        done_o;
  ann_out_t    result_o;

  annealing_acceptance_test uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .item_i(item_i), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .done_o(done_o), .result_o(result_o)
  );

  // shadow registers
  logic [1:0]  cur_profile;
  logic [23:0] cur_max_iter;
  logic [31:0] cur_seed;

  ann_out_t verdicts_q[$];
  int       mismatches;
  int       idle_pct;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #200000000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [63:0] exp2_frac(input logic [63:0] u);
    logic [63:0] n, f, y, term, s;
    n = u >> 32;
    f = u & 64'hFFFF_FFFF;
    if (n >= 33) return 64'd0;
    y = (f * 64'(LN2_Q32)) >> 32;
    term = 64'h1_0000_0000;
    s = 64'h1_0000_0000;
    for (int k = 1; k <= 16; k++) begin
      term = ((term * y) >> 32) / k;
      if (k % 2 == 1) s = s - term;
      else s = s + term;
    end
    return s >> n;
  endfunction

  function automatic logic [63:0] draw_mix(input logic [63:0] seed, cnum, iter);
    logic [63:0] v;
    v = seed + HASH_C1;
    v ^= (cnum + 64'd1) * HASH_C2;
    v ^= (iter + 64'd17) * HASH_C3;
    v ^= v >> 30;
    v = v * HASH_C2;
    v ^= v >> 27;
    v = v * HASH_C3;
    v ^= v >> 31;
    return v;
  endfunction

  function automatic ann_out_t predict_verdict(input ann_in_t it);
    ann_out_t r;
    logic signed [63:0] cur, cand, delta;
    logic [63:0] acur, acand, scale, prog, g, fac, temp, prob, q, rem, init_f, rlog;
    logic [63:0] iter, draw;
    cur = 64'(it.current_score);
    cand = 64'(it.candidate_score);
    iter = 64'(it.iteration_number);
    case (cur_profile)
      PROF_FAST:    begin init_f = 64'(INIT_FAST);    rlog = 64'(RLOG_FAST);    end
      PROF_MAXIMUM: begin init_f = 64'(INIT_MAXIMUM); rlog = 64'(RLOG_MAXIMUM); end
      default:      begin init_f = 64'(INIT_BALANCED); rlog = 64'(RLOG_BALANCED); end
    endcase
    acur = cur < 0 ? -cur : cur;
    acand = cand < 0 ? -cand : cand;
    scale = acur > acand ? acur : acand;
    delta = cand - cur;
    if (cur_max_iter <= 1 || iter >= 64'(cur_max_iter) - 1) prog = 64'h1_0000_0000;
    else prog = (iter << 32) / (64'(cur_max_iter) - 1);
    g = exp2_frac((prog * rlog) >> 28);
    fac = (g * init_f) >> 32;
    temp = ((scale >> 16) * fac + (((scale & 64'hFFFF) * fac) >> 16)) >> 16;
    if (temp < 64'(T_MIN)) temp = 64'(T_MIN);
    if (temp > 64'hFFFF_FFFF_FFFF) temp = 64'hFFFF_FFFF_FFFF;
    r.temperature_value = temp[47:0];
    if (delta <= 0) begin
      r.accepted = 1'b1;
      r.accepted_worse = 1'b0;
      r.probability = ONE_Q32;
      return r;
    end
    if (64'(delta) >= 64 * temp) prob = 0;
    else begin
      q = 64'(delta) / temp;
      rem = 64'(delta) % temp;
      for (int b = 0; b < 32; b++) begin
        rem = rem << 1;
        q = q << 1;
        if (rem >= temp) begin
          rem = rem - temp;
          q[0] = 1'b1;
        end
      end
      prob = exp2_frac((q * 64'(LOG2E_Q24)) >> 24);
    end
    draw = draw_mix(64'(cur_seed), 64'(it.candidate_number), iter) >> 32;
    r.accepted = draw < prob;
    r.accepted_worse = draw < prob;
    r.probability = prob[32:0];
    return r;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    ann_out_t want;
    if (rst_ni && done_o) begin
      if (verdicts_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", result_o);
      end else begin
        want = verdicts_q.pop_front();
        if (result_o.accepted !== want.accepted ||
            result_o.accepted_worse !== want.accepted_worse ||
            result_o.probability !== want.probability ||
            result_o.temperature_value !== want.temperature_value) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p got %p", want, result_o);
        end
      end
    end
  end

  // write enable drops between writes
  task automatic write_reg(input ann_cfg_e idx, input logic [31:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_PROFILE:  cur_profile = val[1:0];
      CFG_MAX_ITER: cur_max_iter = val[23:0];
      default:      cur_seed = val;
    endcase
    @(posedge clk_i);
  endtask

  task automatic drain_pipe();
    while (verdicts_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // one input beat; its predicted verdict is queued once accepted
  task automatic issue_item(input ann_in_t it);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    item_i  <= it;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    verdicts_q.push_back(predict_verdict(it));
  endtask

  function automatic logic [47:0] rand_score();
    logic [47:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(3))
      0: v = 48'(signed'(v[15:0]));
      1: v = 48'(signed'(v[31:0]));
      2: v = 48'(signed'(v[39:0]));
      default: ;
    endcase
    return v;
  endfunction

  typedef struct {
    ann_in_t  it;
    logic     known;
    ann_out_t want;
  } stim_row_t;

  stim_row_t directed[$];

  initial begin
    ann_in_t it;
    ann_out_t w;
    stim_row_t row;
    mismatches = 0;
    idle_pct = 0;
    start_i = 1'b0;
    item_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_PROFILE;
    cfg_data_i = '0;
    cur_profile = PROF_BALANCED;
    cur_max_iter = 24'd1000;
    cur_seed = 32'd0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // equal zero scores after reset: accepted, floor temperature
    w = '{1'b1, 1'b0, ONE_Q32, T_MIN};
    row = '{'{48'sd0, 48'sd0, 24'd0, 32'd0}, 1'b1, w}; directed.push_back(row);
    // better candidate
    row = '{'{48'sd65536, -48'sd65536, 24'd5, 32'd1}, 1'b1, w}; directed.push_back(row);
    // very large delta: probability zero, temperature is scale * 0.01
    w = '{1'b0, 1'b0, 33'd0, 48'd100000};
    row = '{'{48'sd0, 48'sd10000000, 24'd0, 32'd2}, 1'b1, w}; directed.push_back(row);
    // score extremes, both orders
    row.known = 1'b0;
    row.it = '{48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 24'hFFFFFF, 32'hFFFF_FFFF};
    directed.push_back(row);
    row.it = '{48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 24'hFFFFFF, 32'hFFFF_FFFF};
    directed.push_back(row);
    row.it = '{48'h8000_0000_0000, 48'h8000_0000_0000, 24'd998, 32'd0};
    directed.push_back(row);
    // small worse deltas, iterations 0 to 999
    row.it = '{48'sd1000000, 48'sd1000001, 24'd500, 32'd7};  directed.push_back(row);
    row.it = '{48'sd1000000, 48'sd1200000, 24'd100, 32'd8};  directed.push_back(row);
    row.it = '{48'sd0, 48'sd65536, 24'd0, 32'd9};            directed.push_back(row);
    row.it = '{-48'sd5000000, -48'sd4990000, 24'd999, 32'd3}; directed.push_back(row);

    foreach (directed[i]) begin
      issue_item(directed[i].it);
      if (directed[i].known && verdicts_q[$] !== directed[i].want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("table row %0d: expected %p, model gives %p", i,
                   directed[i].want, verdicts_q[$]);
      end
    end
    start_i <= 1'b0;
    drain_pipe();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 64;
        2: idle_pct = 29;
        default: idle_pct = 0;
      endcase
      write_reg(CFG_PROFILE, 32'(ph % 4));  // code 3 falls back to balanced
      case (ph)
        0: write_reg(CFG_MAX_ITER, 32'd0);
        1: write_reg(CFG_MAX_ITER, 32'd1);
        2: write_reg(CFG_MAX_ITER, 32'hFF_FFFF);
        3: write_reg(CFG_MAX_ITER, 32'd2);
        default: write_reg(CFG_MAX_ITER, 32'($urandom_range(2, 5000)));
      endcase
      write_reg(CFG_HASH_SEED, ph == 0 ? 32'd0 : ph == 1 ? 32'hFFFF_FFFF : $urandom);
      for (int n = 0; n < 68; n++) begin
        it.current_score = rand_score();
        case ($urandom_range(3))
          0: it.candidate_score = rand_score();
          1: it.candidate_score = it.current_score + 48'($urandom_range(1, 1 << 20));
          2: it.candidate_score = it.current_score + 48'($urandom);
          default: it.candidate_score = it.current_score - 48'($urandom_range(0, 1000));
        endcase
        it.iteration_number = $urandom_range(1) ? 24'($urandom) :
                              24'($urandom_range(0, cur_max_iter + 2));
        it.candidate_number = $urandom;
        issue_item(it);
      end
      start_i <= 1'b0;
      drain_pipe();
    end

    repeat (PIPE_DEPTH + 10) @(posedge clk_i);
    if (mismatches == 0 && verdicts_q.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
